/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/rmq_pkg.sv */
// Types, widths and helpers for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int NUM_IN     = 9;
    localparam int NUM_Q      = 4;
    localparam int SUM_W      = IN_W + 3;
    localparam int MAG_W      = IN_W + 1;
    localparam int RAD_W      = ((MAG_W + FRAC_BITS + 1) / 2) * 2;
    localparam int SQ_STEPS   = RAD_W / 2;
    localparam int ROOT_W     = SQ_STEPS;
    localparam int DEN_W      = ROOT_W + 1;
    localparam int NUM_W      = MAG_W + FRAC_BITS + 1;
    localparam int QUO_W      = NUM_W - (FRAC_BITS / 2 + 1);
    localparam int WIDE_W     = DEN_W + QUO_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int S_DATA_W   = NUM_IN * IN_W;
    localparam int M_DATA_W   = NUM_Q * OUT_W;

    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1 << FRAC_BITS);
    localparam logic [QUO_W-1:0] POS_MAX = QUO_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(1 << (OUT_W - 1));

    // Classified item handed from front to back
    typedef struct packed {
        logic                        bad;
        logic [NUM_Q-1:0]            neg;
        logic [NUM_Q-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]            trace;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] n;
        begin
            n = -v;
            mag_of = v[SUM_W-1] ? MAG_W'(n) : MAG_W'(v);
        end
    endfunction

endpackage

/* hw/rtl/rmq_front.sv */
// Front end: accepts matrix transfers, picks the trace branch, forms components.
module rmq_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rmq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                        item_valid,
    output rmq_pkg::item_t              item,
    input  logic                        item_ready
);

    logic                          valid_reg;
    rmq_pkg::item_t                item_reg;
    rmq_pkg::item_t                item_next;
    logic signed [rmq_pkg::SUM_W-1:0] v [rmq_pkg::NUM_IN];
    logic signed [rmq_pkg::SUM_W-1:0] t;
    logic signed [rmq_pkg::SUM_W-1:0] q [rmq_pkg::NUM_Q];
    logic signed [rmq_pkg::SUM_W-1:0] cy_sum;

    always_comb begin
        for (int i = 0; i < rmq_pkg::NUM_IN; i++) begin
            v[i] = rmq_pkg::SUM_W'($signed(s_tdata[i*rmq_pkg::IN_W +: rmq_pkg::IN_W]));
        end
    end

    // v: ax ay az bx by bz cx cy cz
    always_comb begin
        cy_sum = v[0] + v[7];
        if (v[5] < 0) begin
            if (v[0] > v[7]) begin
                t = rmq_pkg::ONE + v[0] - v[7] - v[5];
                q[0] = t; q[1] = v[6] + v[1]; q[2] = v[2] + v[3]; q[3] = v[4] - v[8];
            end else begin
                t = rmq_pkg::ONE - v[0] + v[7] - v[5];
                q[0] = v[6] + v[1]; q[1] = t; q[2] = v[4] + v[8]; q[3] = v[2] - v[3];
            end
        end else begin
            if (cy_sum < 0) begin
                t = rmq_pkg::ONE - v[0] - v[7] + v[5];
                q[0] = v[2] + v[3]; q[1] = v[4] + v[8]; q[2] = t; q[3] = v[6] - v[1];
            end else begin
                t = rmq_pkg::ONE + v[0] + v[7] + v[5];
                q[0] = v[4] - v[8]; q[1] = v[2] - v[3]; q[2] = v[6] - v[1]; q[3] = t;
            end
        end
        item_next.bad   = (t <= 0);
        item_next.trace = t[rmq_pkg::MAG_W-1:0];
        for (int i = 0; i < rmq_pkg::NUM_Q; i++) begin
            item_next.neg[i] = q[i][rmq_pkg::SUM_W-1];
            item_next.mag[i] = rmq_pkg::mag_of(q[i]);
        end
    end

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

endmodule

/* hw/rtl/rmq_fifo.sv */
// Short queue decoupling the front end from the arithmetic back end.
module rmq_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rmq_pkg::item_t      push_item,
    input  logic                pop,
    output rmq_pkg::item_t      pop_item,
    output rmq_pkg::fifo_stat_t stat
);

    rmq_pkg::item_t              mem_reg [rmq_pkg::FIFO_DEPTH];
    logic [rmq_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [rmq_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [rmq_pkg::FIFO_AW:0]   count_reg;
    logic [rmq_pkg::FIFO_AW:0]   count_next;
    logic                        do_push;
    logic                        do_pop;

    assign stat.full  = (count_reg == (rmq_pkg::FIFO_AW + 1)'(rmq_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/rmq_back.sv */
// Back end: pipelined square root, four pipelined dividers, saturation, output register.
module rmq_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rmq_pkg::fifo_stat_t          fifo_stat,
    input  rmq_pkg::item_t               fifo_item,
    output logic                         fifo_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rmq_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser
);

    typedef struct packed {
        logic                                         bad;
        logic [rmq_pkg::NUM_Q-1:0]                    neg;
        logic [rmq_pkg::NUM_Q-1:0][rmq_pkg::MAG_W-1:0] mag;
        logic [rmq_pkg::RAD_W-1:0]                    rad;
        logic [rmq_pkg::RAD_W-1:0]                    root;
    } sq_t;

    typedef struct packed {
        logic                                          bad;
        logic [rmq_pkg::NUM_Q-1:0]                     neg;
        logic [rmq_pkg::NUM_Q-1:0][rmq_pkg::NUM_W-1:0] rem;
        logic [rmq_pkg::NUM_Q-1:0][rmq_pkg::QUO_W-1:0] quo;
        logic [rmq_pkg::DEN_W-1:0]                     den;
    } dv_t;

    logic en;
    logic sq_valid_reg [rmq_pkg::SQ_STEPS+1];
    sq_t  sq_reg       [rmq_pkg::SQ_STEPS+1];
    logic dv_valid_reg [rmq_pkg::QUO_W+1];
    dv_t  dv_reg       [rmq_pkg::QUO_W+1];
    logic                          out_valid_reg;
    logic [rmq_pkg::M_DATA_W-1:0]  out_data_reg;
    logic                          out_bad_reg;
    logic [rmq_pkg::M_DATA_W-1:0]  out_data_next;
    dv_t                           dv_first;
    logic [rmq_pkg::ROOT_W-1:0]    root_fin;

    // Whole back end advances together; bubbles ride along
    assign en       = !out_valid_reg || m_tready;
    assign fifo_pop = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sq_valid_reg[0] <= !fifo_stat.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg[0].bad  <= fifo_item.bad;
            sq_reg[0].neg  <= fifo_item.neg;
            sq_reg[0].mag  <= fifo_item.mag;
            sq_reg[0].rad  <= rmq_pkg::RAD_W'(fifo_item.trace) << rmq_pkg::FRAC_BITS;
            sq_reg[0].root <= '0;
        end
    end

    // One result bit of the integer square root per stage
    for (genvar k = 0; k < rmq_pkg::SQ_STEPS; k++) begin : g_sq
        localparam logic [rmq_pkg::RAD_W-1:0] BIT =
            rmq_pkg::RAD_W'(1) << (rmq_pkg::RAD_W - 2 - 2 * k);
        logic [rmq_pkg::RAD_W-1:0] trial;
        sq_t                       nxt;

        always_comb begin
            trial = sq_reg[k].root + BIT;
            nxt   = sq_reg[k];
            if (sq_reg[k].rad >= trial) begin
                nxt.rad  = sq_reg[k].rad - trial;
                nxt.root = (sq_reg[k].root >> 1) + BIT;
            end else begin
                nxt.root = sq_reg[k].root >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[k+1] <= nxt;
            end
        end
    end

    // Dividend = mag * 2^F + s (round half up), divisor = 2s
    always_comb begin
        root_fin     = sq_reg[rmq_pkg::SQ_STEPS].root[rmq_pkg::ROOT_W-1:0];
        dv_first.bad = sq_reg[rmq_pkg::SQ_STEPS].bad;
        dv_first.neg = sq_reg[rmq_pkg::SQ_STEPS].neg;
        dv_first.den = {root_fin, 1'b0};
        dv_first.quo = '0;
        for (int i = 0; i < rmq_pkg::NUM_Q; i++) begin
            dv_first.rem[i] =
                (rmq_pkg::NUM_W'(sq_reg[rmq_pkg::SQ_STEPS].mag[i]) << rmq_pkg::FRAC_BITS)
                + rmq_pkg::NUM_W'(root_fin);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= sq_valid_reg[rmq_pkg::SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg[0] <= dv_first;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < rmq_pkg::QUO_W; j++) begin : g_dv
        localparam int POS = rmq_pkg::QUO_W - 1 - j;
        logic [rmq_pkg::WIDE_W-1:0] shifted;
        dv_t                        nxt;

        always_comb begin
            shifted = rmq_pkg::WIDE_W'(dv_reg[j].den) << POS;
            nxt     = dv_reg[j];
            for (int i = 0; i < rmq_pkg::NUM_Q; i++) begin
                if (rmq_pkg::WIDE_W'(dv_reg[j].rem[i]) >= shifted) begin
                    nxt.rem[i]      = dv_reg[j].rem[i] - shifted[rmq_pkg::NUM_W-1:0];
                    nxt.quo[i][POS] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[j+1] <= nxt;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < rmq_pkg::NUM_Q; i++) begin
            logic [rmq_pkg::QUO_W-1:0] qv;
            logic [rmq_pkg::QUO_W-1:0] qn;
            qv = dv_reg[rmq_pkg::QUO_W].quo[i];
            qn = -qv;
            if (dv_reg[rmq_pkg::QUO_W].bad) begin
                out_data_next[i*rmq_pkg::OUT_W +: rmq_pkg::OUT_W] = '0;
            end else if (dv_reg[rmq_pkg::QUO_W].neg[i]) begin
                out_data_next[i*rmq_pkg::OUT_W +: rmq_pkg::OUT_W] =
                    (qv > rmq_pkg::NEG_MAX) ? rmq_pkg::NEG_MAX[rmq_pkg::OUT_W-1:0]
                                            : qn[rmq_pkg::OUT_W-1:0];
            end else begin
                out_data_next[i*rmq_pkg::OUT_W +: rmq_pkg::OUT_W] =
                    (qv > rmq_pkg::POS_MAX) ? rmq_pkg::POS_MAX[rmq_pkg::OUT_W-1:0]
                                            : qv[rmq_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid_reg[rmq_pkg::QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
            out_bad_reg  <= dv_reg[rmq_pkg::QUO_W].bad;
        end
    end

endmodule

/* hw/rtl/rotation_matrix_to_quaternion_top.sv */
// Rotation matrix (three Q1.14 vectors) to saturated Q1.14 quaternion, stream top level.
// Takes one matrix transfer per clock while s_tready is high and returns one quaternion
// transfer per matrix, in order. Throughput is one item per cycle while the output is
// not stalled. Data passes the front register, queue, square-root input register,
// 16 square-root stages, 1 setup stage, 24 divider stages and output register. m_tuser
// is set when the selected trace term is not positive, and the four components are
// then zero. Back pressure on the output stalls the back end as a whole; the four-entry
// queue keeps the input side taking data while that stall reaches it.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz (16 bits each, lowest first)
    input  logic [rmq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // quat_0, quat_1, quat_2, quat_3 (16 bits each, lowest first)
    output logic [rmq_pkg::M_DATA_W-1:0] m_tdata,
    // bad_trace
    output logic                         m_tuser
);

    logic                item_valid;
    rmq_pkg::item_t      item;
    rmq_pkg::item_t      fifo_item;
    rmq_pkg::fifo_stat_t fifo_stat;
    logic                fifo_pop;

    rmq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (!fifo_stat.full)
    );

    rmq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_valid),
        .push_item (item),
        .pop       (fifo_pop),
        .pop_item  (fifo_item),
        .stat      (fifo_stat)
    );

    rmq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fifo_stat (fifo_stat),
        .fifo_item (fifo_item),
        .fifo_pop  (fifo_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `ASSERT_ALWAYS(a_fifo_state, aclk, aresetn, !(fifo_stat.full && fifo_stat.empty))
    `ASSERT_IMPLY(a_bad_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `ASSERT_IMPLY(a_front_stall, aclk, aresetn, !s_tready, item_valid && fifo_stat.full)

endmodule
